[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked assertions with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ps2mct_pkg.sv]
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker package
// Shared constants and types for the cursor tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2mct_pkg;

    localparam int CoordBitsDefault = 13;
    localparam int SizeBits         = 13;
    localparam int CfgIdxBits       = 2;

    localparam logic [SizeBits-1:0] DefaultWidth  = 13'd1024;
    localparam logic [SizeBits-1:0] DefaultHeight = 13'd768;
    localparam logic [SizeBits-1:0] ResetPosX     = 13'd512;
    localparam logic [SizeBits-1:0] ResetPosY     = 13'd384;

    localparam logic [CfgIdxBits-1:0] CfgScreenWidth  = 2'd0;
    localparam logic [CfgIdxBits-1:0] CfgScreenHeight = 2'd1;

    localparam int BtnLeft  = 0;
    localparam int BtnRight = 1;

    typedef enum logic [1:0] {
        POS_HEADER  = 2'd0,
        POS_DELTA_X = 2'd1,
        POS_DELTA_Y = 2'd2
    } t_byte_pos_e;

endpackage

`default_nettype wire

[hdl/ps2mct_axis_upd.sv]
// ----------------------------------------------------------------------------
// Cursor axis update
// Adds or subtracts a signed 8-bit movement to one coordinate and saturates the
// result to the range from zero to the screen size minus one.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mct_axis_upd
    import ps2mct_pkg::*;
#(
    parameter int                  COORD_BITS   = CoordBitsDefault,
    parameter logic [SizeBits-1:0] DEFAULT_SIZE = DefaultWidth
) (
    input  wire logic [COORD_BITS-1:0] i_pos,
    input  wire logic [7:0]            i_delta,
    input  wire logic                  i_negate,
    input  wire logic [SizeBits-1:0]   i_size,
    output logic      [COORD_BITS-1:0] o_pos
);

    localparam int SumW = COORD_BITS + 2;
    localparam int CmpW = (COORD_BITS + 1 > SizeBits) ? COORD_BITS + 1 : SizeBits;

    logic signed [SumW-1:0]     w_pos;
    logic signed [SumW-1:0]     w_delta;
    logic signed [SumW-1:0]     w_sum;
    logic        [SizeBits-1:0] w_size;
    logic        [SizeBits-1:0] w_size_m1;
    logic        [CmpW-1:0]     w_sum_cmp;
    logic        [CmpW-1:0]     w_size_cmp;

    always_comb begin
        w_pos      = signed'({2'b00, i_pos});
        w_delta    = signed'({{(SumW-8){i_delta[7]}}, i_delta});
        w_sum      = i_negate ? (w_pos - w_delta) : (w_pos + w_delta);
        w_size     = (i_size == '0) ? DEFAULT_SIZE : i_size;
        w_size_m1  = w_size - SizeBits'(1);
        w_sum_cmp  = CmpW'(w_sum[COORD_BITS:0]);
        w_size_cmp = CmpW'(w_size);
        if (w_sum[SumW-1]) begin
            o_pos = '0;
        end else if (w_sum_cmp >= w_size_cmp) begin
            o_pos = COORD_BITS'(w_size_m1);
        end else begin
            o_pos = w_sum[COORD_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

[hdl/ps2_mouse_cursor_tracker.sv]
// The result appears on the output in the cycle after the third packet byte.
// Throughput: one byte per cycle unless stalled; the coordinate update is a
// single add and clamp per axis between the byte input and the position
// registers. The input stalls only while a result waits and is not being taken.
// Reset (synchronous, active low) sets the cursor to 512,384, the screen size
// registers to 1024 by 768 and restarts packet collection at the header byte.
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker
// Gathers three-byte mouse packets from the auxiliary port and keeps a clamped
// cursor position with the button states.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ps2_mouse_cursor_tracker
    import ps2mct_pkg::*;
#(
    parameter int COORD_BITS = CoordBitsDefault
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [CfgIdxBits-1:0] i_cfg_idx,
    input  wire logic [SizeBits-1:0]   i_cfg_wdata,
    // Byte input.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,  // data_byte
    input  wire logic                  s_axis_tuser,  // from_aux
    // Result output.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // cursor_x, cursor_y, left_button, right_button, zero fill
    output logic [((2*COORD_BITS+2+7)/8)*8-1:0] m_axis_tdata
);

    localparam int OutBits = 2 * COORD_BITS + 2;
    localparam int OutW    = ((OutBits + 7) / 8) * 8;

    t_byte_pos_e           r_pos;
    t_byte_pos_e           n_pos;
    logic [SizeBits-1:0]   r_width;
    logic [SizeBits-1:0]   r_height;
    logic [1:0]            r_hdr_btn;
    logic [1:0]            n_hdr_btn;
    logic [7:0]            r_dx;
    logic [7:0]            n_dx;
    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] n_x;
    logic [COORD_BITS-1:0] r_y;
    logic [COORD_BITS-1:0] n_y;
    logic [1:0]            r_out_btn;
    logic [1:0]            n_out_btn;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  w_accept;
    logic [COORD_BITS-1:0] w_upd_x;
    logic [COORD_BITS-1:0] w_upd_y;

    ps2mct_axis_upd #(
        .COORD_BITS   (COORD_BITS),
        .DEFAULT_SIZE (DefaultWidth)
    ) u_upd_x (
        .i_pos    (r_x),
        .i_delta  (r_dx),
        .i_negate (1'b0),
        .i_size   (r_width),
        .o_pos    (w_upd_x)
    );

    ps2mct_axis_upd #(
        .COORD_BITS   (COORD_BITS),
        .DEFAULT_SIZE (DefaultHeight)
    ) u_upd_y (
        .i_pos    (r_y),
        .i_delta  (s_axis_tdata),
        .i_negate (1'b1),
        .i_size   (r_height),
        .o_pos    (w_upd_y)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_pos       = r_pos;
        n_hdr_btn   = r_hdr_btn;
        n_dx        = r_dx;
        n_x         = r_x;
        n_y         = r_y;
        n_out_btn   = r_out_btn;
        n_out_valid = r_out_valid && !m_axis_tready;
        if (w_accept && s_axis_tuser) begin
            case (r_pos)
                POS_HEADER: begin
                    n_hdr_btn = {s_axis_tdata[BtnRight], s_axis_tdata[BtnLeft]};
                    n_pos     = POS_DELTA_X;
                end
                POS_DELTA_X: begin
                    n_dx  = s_axis_tdata;
                    n_pos = POS_DELTA_Y;
                end
                default: begin
                    n_x         = w_upd_x;
                    n_y         = w_upd_y;
                    n_out_btn   = r_hdr_btn;
                    n_out_valid = 1'b1;
                    n_pos       = POS_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_HEADER;
            r_width     <= DefaultWidth;
            r_height    <= DefaultHeight;
            r_x         <= COORD_BITS'(ResetPosX);
            r_y         <= COORD_BITS'(ResetPosY);
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_x         <= n_x;
            r_y         <= n_y;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && (i_cfg_idx == CfgScreenWidth)) begin
                r_width <= i_cfg_wdata;
            end
            if (i_cfg_we && (i_cfg_idx == CfgScreenHeight)) begin
                r_height <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr_btn <= n_hdr_btn;
        r_dx      <= n_dx;
        r_out_btn <= n_out_btn;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OutW'({r_out_btn[1], r_out_btn[0], r_y, r_x});

    `ASSERT_ALWAYS(a_result_from_third_byte, i_clk, i_rst_n,
        $rose(m_axis_tvalid) |->
            $past(w_accept && s_axis_tuser && r_pos != POS_HEADER && r_pos != POS_DELTA_X),
        "A result appeared without a completed packet.")
    `ASSERT_NEXT(a_header_advances, i_clk, i_rst_n,
        w_accept && s_axis_tuser && r_pos == POS_HEADER, r_pos == POS_DELTA_X,
        "The header byte did not advance packet collection.")
    `ASSERT_NEXT(a_plain_byte_ignored, i_clk, i_rst_n,
        w_accept && !s_axis_tuser, $stable(r_pos) && $stable(r_x) && $stable(r_y),
        "A byte from the keyboard port changed the cursor state.")

endmodule

`default_nettype wire

[bench/tb_ps2_mouse_cursor_tracker.sv]
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker testbench
// Feeds controller bytes, both auxiliary and ignored, into the tracker, keeps
// its own model of packet collection and cursor clamping, and compares every
// cursor result with the oldest predicted one. Screen sizes are changed only
// while the tracker is idle, and both stream sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ps2_mouse_cursor_tracker
    import ps2mct_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CoordBits   = CoordBitsDefault;
    localparam int ResultBits  = ((2*CoordBits+2+7)/8)*8;
    localparam int CycleLimit  = 400000;
    localparam int SettleTicks = 4;

    localparam logic [CfgIdxBits-1:0] CfgSpareA = 2'd2;
    localparam logic [CfgIdxBits-1:0] CfgSpareB = 2'd3;

    typedef struct packed {
        logic [CoordBits-1:0] cx;
        logic [CoordBits-1:0] cy;
        logic                 btn_l;
        logic                 btn_r;
    } t_cursor;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CfgIdxBits-1:0] i_cfg_idx = '0;
    logic [SizeBits-1:0]   i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [ResultBits-1:0] m_axis_tdata;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    // Model of the tracker.
    t_byte_pos_e          pkt_pos;
    logic [7:0]           hdr_byte;
    logic [7:0]           dx_byte;
    logic [CoordBits-1:0] pos_x;
    logic [CoordBits-1:0] pos_y;
    logic [SizeBits-1:0]  width_reg;
    logic [SizeBits-1:0]  height_reg;

    t_cursor expected_cursor_q[$];

    ps2_mouse_cursor_tracker #(
        .COORD_BITS(CoordBits)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic logic [CoordBits-1:0] clamp_coord(input int v,
                                                         input logic [SizeBits-1:0] size_reg,
                                                         input logic [SizeBits-1:0] dflt);
        logic [SizeBits-1:0] sz;
        sz = size_reg;
        if (sz == '0)
            sz = dflt;
        if (v < 0)
            return '0;
        if (v >= int'(sz))
            return CoordBits'(sz - 1'b1);
        return CoordBits'(v);
    endfunction

    function automatic void reset_tracker();
        pkt_pos    = POS_HEADER;
        hdr_byte   = '0;
        dx_byte    = '0;
        pos_x      = ResetPosX;
        pos_y      = ResetPosY;
        width_reg  = DefaultWidth;
        height_reg = DefaultHeight;
    endfunction

    function automatic void track_byte(input logic [7:0] b, input logic aux);
        int      nx;
        int      ny;
        t_cursor c;
        if (!aux)
            return;
        case (pkt_pos)
            POS_HEADER: begin
                hdr_byte = b;
                pkt_pos  = POS_DELTA_X;
            end
            POS_DELTA_X: begin
                dx_byte = b;
                pkt_pos = POS_DELTA_Y;
            end
            default: begin
                pkt_pos = POS_HEADER;
                nx = int'(pos_x) + int'($signed(dx_byte));
                ny = int'(pos_y) - int'($signed(b));
                pos_x = clamp_coord(nx, width_reg, DefaultWidth);
                pos_y = clamp_coord(ny, height_reg, DefaultHeight);
                c.cx    = pos_x;
                c.cy    = pos_y;
                c.btn_l = hdr_byte[BtnLeft];
                c.btn_r = hdr_byte[BtnRight];
                expected_cursor_q.push_back(c);
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_cursor got;
        t_cursor want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.cx    = m_axis_tdata[CoordBits-1:0];
            got.cy    = m_axis_tdata[2*CoordBits-1:CoordBits];
            got.btn_l = m_axis_tdata[2*CoordBits];
            got.btn_r = m_axis_tdata[2*CoordBits+1];
            if (expected_cursor_q.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("unexpected cursor item: x=%0d y=%0d l=%0b r=%0b",
                             got.cx, got.cy, got.btn_l, got.btn_r);
            end else begin
                want = expected_cursor_q.pop_front();
                if (got.cx !== want.cx || got.cy !== want.cy ||
                        got.btn_l !== want.btn_l || got.btn_r !== want.btn_r) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("cursor mismatch: expected x=%0d y=%0d l=%0b r=%0b,",
                                 want.cx, want.cy, want.btn_l, want.btn_r,
                                 " got x=%0d y=%0d l=%0b r=%0b",
                                 got.cx, got.cy, got.btn_l, got.btn_r);
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic aux);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= aux;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        track_byte(b, aux);
    endtask

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx,
                               input logic [7:0] dy, input bit noisy);
        logic [7:0] bytes[3];
        bytes = '{hdr, dx, dy};
        foreach (bytes[k]) begin
            if (noisy && $urandom_range(0, 9) == 0)
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_byte(bytes[k], 1'b1);
        end
    endtask

    // Waits until every predicted cursor has arrived and the pipeline is empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_cursor_q.size() != 0)
            @(posedge i_clk);
        repeat (SettleTicks) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [SizeBits-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx == CfgScreenWidth)
            width_reg = val;
        else if (idx == CfgScreenHeight)
            height_reg = val;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_delta(input int dir);
        if (dir > 0)
            return 8'($urandom_range(8'h70, 8'h7F));
        if (dir < 0)
            return 8'($urandom_range(8'h80, 8'h8F));
        case ($urandom_range(0, 7))
            0: return 8'h7F;
            1: return 8'h80;
            2: return 8'h00;
            3: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_packets(input int count);
        int mode;
        int dir;
        mode = 0;
        for (int i = 0; i < count; i++) begin
            if (i % 10 == 0)
                mode = $urandom_range(0, 3);
            dir = (mode == 2) ? 1 : (mode == 3) ? -1 : 0;
            send_packet(8'($urandom_range(0, 255)), pick_delta(dir), pick_delta(-dir), 1'b1);
        end
    endtask

    task automatic test_reset_position();
        send_packet(8'h08, 8'h00, 8'h00, 1'b0);
    endtask

    task automatic test_buttons_and_flags();
        send_packet(8'h01, 8'h7F, 8'h80, 1'b0);
        send_packet(8'h02, 8'h80, 8'h7F, 1'b0);
        send_packet(8'h03, 8'hFF, 8'h01, 1'b0);
        // Sign and overflow bits set in the header must not affect movement.
        send_packet(8'hF8, 8'h01, 8'hFF, 1'b0);
    endtask

    task automatic test_ignored_bytes();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h09, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h10, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hF0, 1'b1);
    endtask

    task automatic test_spare_index();
        settle();
        write_reg(CfgSpareA, '0);
        write_reg(CfgSpareB, '1);
        send_packet(8'h00, 8'h7F, 8'h7F, 1'b0);
    endtask

    task automatic test_shrunk_screen();
        settle();
        write_reg(CfgScreenWidth, 13'd100);
        write_reg(CfgScreenHeight, 13'd50);
        send_packet(8'h03, 8'h00, 8'h00, 1'b0);
        settle();
        write_reg(CfgScreenWidth, 13'd1);
        write_reg(CfgScreenHeight, 13'd1);
        send_packet(8'h00, 8'h7F, 8'h80, 1'b0);
    endtask

    task automatic test_zero_size_phase();
        send_idle_pct = 14;
        recv_idle_pct = 46;
        settle();
        write_reg(CfgScreenWidth, '0);
        write_reg(CfgScreenHeight, '0);
        random_packets(75);
        settle();
        random_packets(75);
    endtask

    task automatic test_wide_screen_phase();
        send_idle_pct = 46;
        recv_idle_pct = 14;
        settle();
        write_reg(CfgScreenWidth, '1);
        write_reg(CfgScreenHeight, '1);
        // Drive the cursor all the way into the far corner first.
        for (int i = 0; i < 80; i++)
            send_packet(8'($urandom_range(0, 255)), pick_delta(1), pick_delta(-1), 1'b1);
        random_packets(70);
    endtask

    task automatic test_small_screen_phase();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        settle();
        write_reg(CfgScreenWidth, 13'($urandom_range(1, 2000)));
        write_reg(CfgScreenHeight, 13'($urandom_range(1, 2000)));
        random_packets(50);
        settle();
        write_reg(CfgScreenWidth, 13'd8191);
        write_reg(CfgScreenHeight, 13'd0);
        random_packets(50);
        settle();
        write_reg(CfgScreenWidth, 13'd2);
        write_reg(CfgScreenHeight, 13'd8191);
        random_packets(50);
    endtask

    initial begin
        reset_tracker();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_position();
        test_buttons_and_flags();
        test_ignored_bytes();
        test_spare_index();
        test_shrunk_screen();
        test_zero_size_phase();
        test_wide_screen_phase();
        test_small_screen_phase();

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_cursor_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
